### rtl/pep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_pkg
// Types, codes and unlock tables for the parallel EEPROM programmer.
// ----------------------------------------------------------------------------
package pep_pkg;

  localparam int PACKET_BYTES_DEF = 64;
  localparam int CHUNK_W          = 7;
  localparam int ADDR_W           = 16;
  localparam int BUS_ADDR_W       = 15;
  localparam int REM_W            = 17;
  localparam int UNLOCK_LEN       = 6;
  localparam int IDX_W            = 3;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_HEADER   = 2'd0,
    OP_HOST     = 2'd1,
    OP_BUS      = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_RDREQ  = 2'd1,
    K_HOST   = 2'd2,
    K_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WDATA = 2'd2,
    PH_POLL  = 2'd3
  } phase_t;

  localparam logic [7:0] CMD_READ  = 8'h52;
  localparam logic [7:0] CMD_WRITE = 8'h57;
  localparam logic [7:0] CMD_PAGE  = 8'h50;
  localparam logic [7:0] CMD_ERASE = 8'h5A;

  typedef struct packed {
    kind_t                  kind;
    logic [BUS_ADDR_W-1:0]  bus_addr;
    logic [7:0]             bus_wdata;
    logic [7:0]             read_byte;
    logic                   host_packet_end;
    logic [ADDR_W-1:0]      final_addr;
  } res_t;

  function automatic logic [BUS_ADDR_W-1:0] unlock_addr(input logic [IDX_W-1:0] idx);
    logic [BUS_ADDR_W-1:0] a;
    case (idx)
      3'd1, 3'd4: a = 15'h2AAA;
      default:    a = 15'h5555;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] unlock_data(input logic [IDX_W-1:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = 8'hAA;
      3'd1:    d = 8'h55;
      3'd2:    d = 8'h80;
      3'd3:    d = 8'hAA;
      3'd4:    d = 8'h55;
      default: d = 8'h10;
    endcase
    return d;
  endfunction

endpackage

### rtl/parallel_eeprom_programmer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_eeprom_programmer_top
// Command engine that turns host commands into parallel EEPROM bus cycles.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries host command headers, host data bytes and bytes
//   sampled on the memory bus; in_tuser selects which. The output stream
//   carries bus write cycles, bus read requests, bytes for the host and the
//   final status of a command; out_tuser gives the kind and out_tlast marks
//   the last result caused by one input transaction.
//   Each input is decoded and the state updated in the cycle it is taken;
//   its results start on the output in the next cycle, one result per cycle
//   while the receiver is ready. Most inputs cause at most two results; an
//   erase causes seven. Throughput: one input per cycle while the receiver
//   is ready and the input causes at most one result; otherwise one input
//   per result, set by the single output register draining its burst. The
//   next input is taken in the cycle the burst's last result leaves, so
//   back-to-back traffic has no idle gap. No-result inputs load nothing.
//   Reset returns the engine to idle with all counters cleared and drops
//   any pending result. A stalled receiver holds the current result and
//   blocks new input once the burst register is full.
// ----------------------------------------------------------------------------
module parallel_eeprom_programmer_top #(
  parameter int PACKET_BYTES = pep_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: cmd_code[7:0], start_addr[23:8], count_minus_one[39:24],
  //           host_byte[47:40], bus_byte[55:48]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pep_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]                     in_tuser,
  // in_tlast: host_packet_last
  input  logic                           in_tlast,
  // out_tdata: bus_addr[14:0], bus_wdata[22:15], read_byte[30:23],
  //            host_packet_end[31], final_addr[47:32]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pep_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: kind[1:0]
  output logic [1:0]                     out_tuser,
  // out_tlast: last
  output logic                           out_tlast
);

  localparam logic [pep_pkg::CHUNK_W-1:0] PKT_LIM = pep_pkg::CHUNK_W'(PACKET_BYTES);

  // state
  pep_pkg::phase_t                phase_r, phase_nxt;
  logic                           page_r, page_nxt;
  logic [pep_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [pep_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [7:0]                     epb_r, epb_nxt;
  logic                           pcp_r, pcp_nxt;
  logic [pep_pkg::CHUNK_W-1:0]    chunk_r, chunk_nxt;

  // burst register
  logic                           ovld_r;
  logic                           erase_r, erase_nxt;
  logic [pep_pkg::IDX_W-1:0]      idx_r;
  logic [pep_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  pep_pkg::res_t                  r0_r, r0_nxt, r1_r, r1_nxt;

  // input fields
  pep_pkg::op_t                   op;
  logic [7:0]                     cmd;
  logic [pep_pkg::ADDR_W-1:0]     saddr;
  logic [pep_pkg::ADDR_W-1:0]     cntm1;
  logic [7:0]                     hbyte;
  logic [7:0]                     bbyte;

  logic                           in_acc, out_acc, out_last;
  logic [pep_pkg::REM_W-1:0]      rem_dec;
  logic [pep_pkg::CHUNK_W-1:0]    chunk_inc;
  logic [pep_pkg::ADDR_W-1:0]     addr_inc;
  pep_pkg::res_t                  cur;

  assign op    = pep_pkg::op_t'(in_tuser);
  assign cmd   = in_tdata[7:0];
  assign saddr = in_tdata[23:8];
  assign cntm1 = in_tdata[39:24];
  assign hbyte = in_tdata[47:40];
  assign bbyte = in_tdata[55:48];

  assign out_last  = (idx_r == cnt_r - 1'b1);
  assign out_acc   = out_tvalid && out_tready;
  assign in_tready = !ovld_r || (out_acc && out_last);
  assign in_acc    = in_tvalid && in_tready;

  assign rem_dec   = (rem_r != '0) ? rem_r - 1'b1 : '0;
  assign chunk_inc = chunk_r + 1'b1;
  assign addr_inc  = addr_r + 1'b1;

  // decode one item and update state
  always_comb begin
    phase_nxt = phase_r;
    page_nxt  = page_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    epb_nxt   = epb_r;
    pcp_nxt   = pcp_r;
    chunk_nxt = chunk_r;
    erase_nxt = 1'b0;
    cnt_nxt   = '0;
    r0_nxt    = '0;
    r1_nxt    = '0;
    if (phase_r == pep_pkg::PH_IDLE && op == pep_pkg::OP_HEADER) begin
      unique case (cmd)
        pep_pkg::CMD_READ: begin
          addr_nxt         = saddr;
          rem_nxt          = {1'b0, cntm1} + 1'b1;
          chunk_nxt        = '0;
          pcp_nxt          = 1'b0;
          phase_nxt        = pep_pkg::PH_READ;
          r0_nxt.kind      = pep_pkg::K_RDREQ;
          r0_nxt.bus_addr  = saddr[pep_pkg::BUS_ADDR_W-1:0];
          cnt_nxt          = 3'd1;
        end
        pep_pkg::CMD_WRITE, pep_pkg::CMD_PAGE: begin
          addr_nxt  = saddr;
          rem_nxt   = {1'b0, cntm1} + 1'b1;
          chunk_nxt = '0;
          pcp_nxt   = 1'b0;
          page_nxt  = (cmd == pep_pkg::CMD_PAGE);
          phase_nxt = pep_pkg::PH_WDATA;
        end
        pep_pkg::CMD_ERASE: begin
          addr_nxt  = '0;
          rem_nxt   = '0;
          erase_nxt = 1'b1;
          cnt_nxt   = 3'(pep_pkg::UNLOCK_LEN + 1);
        end
        default: ;
      endcase
    end else if (phase_r == pep_pkg::PH_READ && op == pep_pkg::OP_BUS) begin
      rem_nxt                = rem_dec;
      addr_nxt               = addr_inc;
      r0_nxt.kind            = pep_pkg::K_HOST;
      r0_nxt.read_byte       = bbyte;
      r0_nxt.host_packet_end = (chunk_inc >= PKT_LIM) || (rem_dec == '0);
      chunk_nxt              = r0_nxt.host_packet_end ? '0 : chunk_inc;
      cnt_nxt                = 3'd2;
      if (rem_dec == '0) begin
        r1_nxt.kind       = pep_pkg::K_STATUS;
        r1_nxt.final_addr = addr_inc;
        phase_nxt         = pep_pkg::PH_IDLE;
      end else begin
        r1_nxt.kind     = pep_pkg::K_RDREQ;
        r1_nxt.bus_addr = addr_inc[pep_pkg::BUS_ADDR_W-1:0];
      end
    end else if (phase_r == pep_pkg::PH_WDATA && op == pep_pkg::OP_HOST) begin
      r0_nxt.kind      = pep_pkg::K_WRITE;
      r0_nxt.bus_addr  = addr_r[pep_pkg::BUS_ADDR_W-1:0];
      r0_nxt.bus_wdata = hbyte;
      addr_nxt         = addr_inc;
      rem_nxt          = rem_dec;
      cnt_nxt          = 3'd1;
      if (!page_r || in_tlast) begin
        epb_nxt         = hbyte;
        pcp_nxt         = in_tlast;
        phase_nxt       = pep_pkg::PH_POLL;
        r1_nxt.kind     = pep_pkg::K_RDREQ;
        r1_nxt.bus_addr = addr_r[pep_pkg::BUS_ADDR_W-1:0];
        cnt_nxt         = 3'd2;
      end
    end else if (phase_r == pep_pkg::PH_POLL && op == pep_pkg::OP_BUS) begin
      if (bbyte != epb_r) begin
        // poll again at the byte just written
        r0_nxt.kind     = pep_pkg::K_RDREQ;
        r0_nxt.bus_addr = addr_r[pep_pkg::BUS_ADDR_W-1:0] - 1'b1;
        cnt_nxt         = 3'd1;
      end else if (pcp_r && rem_r == '0) begin
        pcp_nxt           = 1'b0;
        r0_nxt.kind       = pep_pkg::K_STATUS;
        r0_nxt.final_addr = addr_r;
        phase_nxt         = pep_pkg::PH_IDLE;
        cnt_nxt           = 3'd1;
      end else begin
        pcp_nxt   = 1'b0;
        phase_nxt = pep_pkg::PH_WDATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pep_pkg::PH_IDLE;
      page_r  <= 1'b0;
      addr_r  <= '0;
      rem_r   <= '0;
      epb_r   <= '0;
      pcp_r   <= 1'b0;
      chunk_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      page_r  <= page_nxt;
      addr_r  <= addr_nxt;
      rem_r   <= rem_nxt;
      epb_r   <= epb_nxt;
      pcp_r   <= pcp_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  // burst register: load on a transaction with results, advance per output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      idx_r  <= '0;
    end else if (in_acc && cnt_nxt != '0) begin
      ovld_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_acc) begin
      if (out_last) begin
        ovld_r <= 1'b0;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cnt_nxt != '0) begin
      erase_r <= erase_nxt;
      cnt_r   <= cnt_nxt;
      r0_r    <= r0_nxt;
      r1_r    <= r1_nxt;
    end
  end

  always_comb begin
    cur = '0;
    if (erase_r) begin
      if (idx_r < 3'(pep_pkg::UNLOCK_LEN)) begin
        cur.kind      = pep_pkg::K_WRITE;
        cur.bus_addr  = pep_pkg::unlock_addr(idx_r);
        cur.bus_wdata = pep_pkg::unlock_data(idx_r);
      end else begin
        cur.kind = pep_pkg::K_STATUS;
      end
    end else begin
      cur = (idx_r == '0) ? r0_r : r1_r;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = cur.kind;
  assign out_tlast  = out_last;
  assign out_tdata  = {cur.final_addr, cur.host_packet_end, cur.read_byte,
                       cur.bus_wdata, cur.bus_addr};

endmodule
